// File: rtl/pixel_row_run_length_encoder_defines.svh
// Assertion macros for the pixel row run-length encoder.
// Included by the top level; no other dependencies.
`ifndef PIXEL_ROW_RUN_LENGTH_ENCODER_DEFINES_SVH
`define PIXEL_ROW_RUN_LENGTH_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define PRRLE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("prrle assertion failed");
// Clocked check without reset masking.
`define PRRLE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("prrle assertion failed");
`else
`define PRRLE_ASSERT(label, clk, rst_n, prop)
`define PRRLE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/prrle_pkg.sv
// Shared constants and types for the pixel row run-length encoder.
// No dependencies.
package prrle_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_W      = 11;
    localparam int PIX_W      = 24;
    localparam int FLD_W      = 10;
    localparam int BURST_N    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd2;

    typedef struct packed {
        logic [FLD_W-1:0] row_index;
        logic [FLD_W-1:0] start_column;
        logic [FLD_W-1:0] end_column;
        logic [PIX_W-1:0] run_color;
        logic             is_end_marker;
        logic             last_of_burst;
    } t_rec;

    typedef struct packed {
        logic [BURST_N-1:0]      vld;
        t_rec [BURST_N-1:0]      rec;
    } t_burst;

    // Last index of a dimension: 0 acts as 1, oversize saturates.
    function automatic logic [31:0] dim_last(input logic [DIM_W-1:0] v, input int maxv);
        logic [31:0] e;
        if (v == '0) begin
            e = 32'd1;
        end else if (32'(v) > 32'(maxv)) begin
            e = 32'(maxv);
        end else begin
            e = 32'(v);
        end
        return e - 32'd1;
    endfunction

endpackage

// File: rtl/prrle_core.sv
// Run tracker: holds the open run and position, forms up to three records per pixel.
// Depends on prrle_pkg.
module prrle_core import prrle_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output t_burst                o_burst
);

    logic [COL_W-1:0] r_width_last, n_width_last;
    logic [ROW_W-1:0] r_height_last, n_height_last;
    logic [PIX_W-1:0] r_color_key;
    logic [PIX_W-1:0] r_run_pixel, n_run_pixel;
    logic [COL_W-1:0] r_run_start, n_run_start;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             change, row_end, v0, v1, v2;

    always_comb begin
        change = (r_col != '0) && (i_pixel_value != r_run_pixel);
        if (r_col == '0) begin
            n_run_pixel = i_pixel_value;
            n_run_start = '0;
        end else if (change) begin
            n_run_pixel = i_pixel_value;
            n_run_start = r_col;
        end else begin
            n_run_pixel = r_run_pixel;
            n_run_start = r_run_start;
        end
        row_end = (r_col >= r_width_last);
        if (row_end) begin
            n_col = '0;
            n_row = (r_row == '0) ? r_height_last : r_row - 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
        // transparent runs are dropped
        v0 = change && (r_run_pixel != '0) && (r_run_pixel != r_color_key);
        v1 = row_end && (n_run_pixel != '0) && (n_run_pixel != r_color_key);
        v2 = row_end && (r_row == '0);

        o_burst.vld = {v2, v1, v0};
        o_burst.rec[0].row_index     = FLD_W'(r_row);
        o_burst.rec[0].start_column  = FLD_W'(r_run_start);
        o_burst.rec[0].end_column    = FLD_W'(r_col - 1'b1);
        o_burst.rec[0].run_color     = r_run_pixel;
        o_burst.rec[0].is_end_marker = 1'b0;
        o_burst.rec[0].last_of_burst = !v1 && !v2;
        o_burst.rec[1].row_index     = FLD_W'(r_row);
        o_burst.rec[1].start_column  = FLD_W'(n_run_start);
        o_burst.rec[1].end_column    = FLD_W'(r_col);
        o_burst.rec[1].run_color     = n_run_pixel;
        o_burst.rec[1].is_end_marker = 1'b0;
        o_burst.rec[1].last_of_burst = !v2;
        o_burst.rec[2]               = '0;
        o_burst.rec[2].is_end_marker = 1'b1;
        o_burst.rec[2].last_of_burst = 1'b1;

        n_width_last  = r_width_last;
        n_height_last = r_height_last;
        if (i_cfg_we && (i_cfg_index == CFG_WIDTH)) begin
            n_width_last = COL_W'(dim_last(i_cfg_data[DIM_W-1:0], MAX_WIDTH));
        end
        if (i_cfg_we && (i_cfg_index == CFG_HEIGHT)) begin
            n_height_last = ROW_W'(dim_last(i_cfg_data[DIM_W-1:0], MAX_HEIGHT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_last  <= COL_W'(MAX_WIDTH - 1);
            r_height_last <= ROW_W'(MAX_HEIGHT - 1);
            r_color_key   <= '0;
            r_run_pixel   <= '0;
            r_run_start   <= '0;
            r_col         <= '0;
            r_row         <= ROW_W'(MAX_HEIGHT - 1);
        end else if (i_cfg_we) begin
            r_width_last  <= n_width_last;
            r_height_last <= n_height_last;
            if (i_cfg_index == CFG_KEY) begin
                r_color_key <= i_cfg_data[PIX_W-1:0];
            end
            // geometry write restarts the image
            if (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT) begin
                r_run_pixel <= '0;
                r_run_start <= '0;
                r_col       <= '0;
                r_row       <= n_height_last;
            end
        end else if (i_accept) begin
            r_run_pixel <= n_run_pixel;
            r_run_start <= n_run_start;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

endmodule

// File: rtl/prrle_fifo.sv
// Record queue: takes up to three records at once, hands one out per read cycle.
// Depends on prrle_pkg.
module prrle_fifo import prrle_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_burst i_burst,
    input  logic   i_rd,
    output logic   o_nonempty,
    output logic   o_room,
    output logic [2:0] o_count,
    output t_rec   o_rec
);

    t_rec       r_mem [4];
    logic [1:0] r_head, r_tail, n_tail;
    logic [2:0] r_count, n_count;
    logic [1:0] off1, off2, nwr;

    always_comb begin
        off1 = {1'b0, i_burst.vld[0]};
        off2 = off1 + {1'b0, i_burst.vld[1]};
        nwr  = i_wr ? off2 + {1'b0, i_burst.vld[2]} : 2'd0;
        n_tail  = r_tail + nwr;
        n_count = r_count + {1'b0, nwr} - {2'b0, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_rd) begin
                r_head <= r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && i_burst.vld[0]) begin
            r_mem[r_tail] <= i_burst.rec[0];
        end
        if (i_wr && i_burst.vld[1]) begin
            r_mem[r_tail + off1] <= i_burst.rec[1];
        end
        if (i_wr && i_burst.vld[2]) begin
            r_mem[r_tail + off2] <= i_burst.rec[2];
        end
    end

    assign o_nonempty = (r_count != '0);
    assign o_room     = (r_count <= 3'd1);
    assign o_count    = r_count;
    assign o_rec      = r_mem[r_head];

endmodule

// File: rtl/pixel_row_run_length_encoder.sv
// Pixel row run-length encoder with transparent color key.
// Pixels enter on i_valid/o_stall (one 24-bit pixel per request, raster order,
// rows numbered from image_height-1 down to 0). Records leave on o_valid/i_stall:
// row, start and end column, color, end-marker and last-of-burst flags.
// A pixel is taken when i_valid is high and o_stall is low; a record is taken
// when o_valid is high and i_stall is low.
// A record enters the record queue when the pixel that closes its run is taken.
// One pixel per cycle while i_stall is low and a pixel closes at most one run.
// A pixel can close up to three records (color change, row end, end marker);
// the four-entry record queue drains one record per cycle while i_stall is low,
// and o_stall rises whenever more than one record is queued, so the records of
// a burst leave the output port one after another.
// Receiver stall: records wait in the queue, payload held steady; input keeps
// flowing until the queue holds two records.
// Reset (synchronous, active low): width and height 1024, key 0, empty queue,
// run state cleared. Writing width or height abandons the image in progress.
// Make configuration writes only while the block is idle; it does not enforce this.
// Depends on prrle_pkg, prrle_core, prrle_fifo and the assertion macro header.
`include "pixel_row_run_length_encoder_defines.svh"
module pixel_row_run_length_encoder import prrle_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FLD_W-1:0]      o_row_index,
    output logic [FLD_W-1:0]      o_start_column,
    output logic [FLD_W-1:0]      o_end_column,
    output logic [PIX_W-1:0]      o_run_color,
    output logic                  o_is_end_marker,
    output logic                  o_last_of_burst
);

    t_burst     burst;
    t_rec       head;
    logic       in_acc, out_acc, room, nonempty;
    logic [2:0] q_count;

    // queue room depends only on the registered count
    assign o_stall = !room;
    assign in_acc  = i_valid && room;
    assign out_acc = nonempty && !i_stall;

    prrle_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_acc),
        .i_pixel_value (i_pixel_value),
        .o_burst       (burst)
    );

    prrle_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (in_acc),
        .i_burst    (burst),
        .i_rd       (out_acc),
        .o_nonempty (nonempty),
        .o_room     (room),
        .o_count    (q_count),
        .o_rec      (head)
    );

    assign o_valid         = nonempty;
    assign o_row_index     = head.row_index;
    assign o_start_column  = head.start_column;
    assign o_end_column    = head.end_column;
    assign o_run_color     = head.run_color;
    assign o_is_end_marker = head.is_end_marker;
    assign o_last_of_burst = head.last_of_burst;

    // queue never overflows its four entries
    `PRRLE_ASSERT(a_queue_bound, i_clk, i_rst_n, q_count <= 3'd4)
    // a pixel is only taken when a full burst fits
    `PRRLE_ASSERT(a_accept_room, i_clk, i_rst_n, in_acc |-> q_count <= 3'd1)
    // end marker carries all-zero fields
    `PRRLE_ASSERT(a_marker_zero, i_clk, i_rst_n, (o_valid && o_is_end_marker) |-> (o_row_index == '0 && o_start_column == '0 && o_end_column == '0 && o_run_color == '0))
    // run records never end before they start
    `PRRLE_ASSERT(a_run_order, i_clk, i_rst_n, (o_valid && !o_is_end_marker) |-> (o_end_column >= o_start_column))

endmodule

// File: bench/tb_pixel_row_run_length_encoder.sv
// Self-checking testbench for pixel_row_run_length_encoder: directed table, then random
// images over many geometries and color keys, checked against an in-bench run predictor.
// Depends on prrle_pkg and the encoder RTL only.
module tb_pixel_row_run_length_encoder;
    import prrle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 190;  // random pixels in the small-image phases
    localparam int LONG_ITEMS     = 24;   // pixels in each saturated-geometry phase
    localparam int HOLD_CYCLES    = 60;   // long receiver hold-off, fills the record queue
    localparam int SETTLE_CYCLES  = 4;    // a pixel that closes nothing may still be in flight
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no request moving on either side

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [FLD_W-1:0]      o_row_index;
    logic [FLD_W-1:0]      o_start_column;
    logic [FLD_W-1:0]      o_end_column;
    logic [PIX_W-1:0]      o_run_color;
    logic                  o_is_end_marker;
    logic                  o_last_of_burst;

    pixel_row_run_length_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_value   (i_pixel_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_row_index     (o_row_index),
        .o_start_column  (o_start_column),
        .o_end_column    (o_end_column),
        .o_run_color     (o_run_color),
        .o_is_end_marker (o_is_end_marker),
        .o_last_of_burst (o_last_of_burst)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Run predictor: its own copy of the registers and the open run
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] cfg_width  = DIM_W'(1024);
    logic [DIM_W-1:0] cfg_height = DIM_W'(1024);
    logic [PIX_W-1:0] cfg_key    = '0;

    logic [PIX_W-1:0] open_color;  // color of the run still being built
    logic [FLD_W-1:0] open_start;  // its first column
    logic [FLD_W-1:0] next_col;    // column of the next pixel
    logic [FLD_W-1:0] next_row;    // row of the next pixel, counts down

    t_rec expected_records[$];     // records owed by the DUT, oldest first

    // Zero acts as one, anything above the cap saturates.
    function automatic int eff_size(input logic [DIM_W-1:0] v, input int cap);
        if (v == '0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    function automatic void restart_image();
        open_color = '0;
        open_start = '0;
        next_col   = '0;
        next_row   = FLD_W'(eff_size(cfg_height, MAX_HEIGHT) - 1);
    endfunction

    // Transparent runs (black or the key color) close silently.
    function automatic void close_run(ref t_rec burst[$], input logic [FLD_W-1:0] last_col);
        t_rec r;
        if (open_color == '0 || open_color == cfg_key) return;
        r = '{next_row, open_start, last_col, open_color, 1'b0, 1'b0};
        burst.push_back(r);
    endfunction

    // One pixel in, up to three records out: color change, row end, end of image.
    function automatic void encode_pixel(input logic [PIX_W-1:0] pix, ref t_rec burst[$]);
        int               w;
        logic [FLD_W-1:0] col;
        t_rec             marker;
        w   = eff_size(cfg_width, MAX_WIDTH);
        col = next_col;
        if (col == '0) begin
            open_color = pix;
            open_start = '0;
        end else if (pix != open_color) begin
            close_run(burst, col - 1'b1);
            open_color = pix;
            open_start = col;
        end
        if (int'(col) >= w - 1) begin
            close_run(burst, col);
            next_col = '0;
            if (next_row == '0) begin
                marker = '{'0, '0, '0, '0, 1'b1, 1'b0};
                burst.push_back(marker);
                next_row = FLD_W'(eff_size(cfg_height, MAX_HEIGHT) - 1);
            end else begin
                next_row = next_row - 1'b1;
            end
        end else begin
            next_col = col + 1'b1;
        end
        if (burst.size() > 0) burst[burst.size()-1].last_of_burst = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Run control shared by the sender, the receiver and the sequence
    // ------------------------------------------------------------------
    bit               tx_idle_on   = 1'b1;  // sender draws a gap before each pixel
    bit               rx_idle_on   = 1'b1;  // receiver draws a stall before each record
    bit               hold_off_req = 1'b0;  // ask the receiver for one long hold-off
    logic [PIX_W-1:0] palette [4];          // colors that form runs in random images
    int               errors          = 0;
    int               pixels_sent     = 0;
    int               records_checked = 0;
    int               writes_done     = 0;

    // Drop valid and wait until the DUT owes nothing, plus the in-flight margin.
    task automatic pause_sender();
        i_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        pause_sender();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        writes_done++;
        case (idx)
            CFG_WIDTH: begin
                cfg_width = val[DIM_W-1:0];
                restart_image();
            end
            CFG_HEIGHT: begin
                cfg_height = val[DIM_W-1:0];
                restart_image();
            end
            CFG_KEY: cfg_key = val[PIX_W-1:0];
            default: ;
        endcase
    endtask

    // One pixel request. Valid is raised once per step and held until taken.
    // n_known < 0: the predictor supplies the records; otherwise the typed
    // record (n_known == 1) or nothing (n_known == 0) is owed instead.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input int gap,
                              input int n_known, input t_rec known);
        t_rec burst[$];
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        pixels_sent++;
        encode_pixel(pix, burst);
        if (n_known < 0) begin
            foreach (burst[k]) expected_records.push_back(burst[k]);
        end else if (n_known == 1) begin
            expected_records.push_back(known);
        end
    endtask

    // Mostly runs of palette colors, now and then a fully random pixel.
    task automatic run_pixels(input int count, input int repeat_pct);
        logic [PIX_W-1:0] pix;
        int               pick;
        pix = palette[0];
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick >= repeat_pct) begin
                if (pick < 92) pix = palette[$urandom_range(0, 3)];
                else pix = PIX_W'($urandom);
            end
            send_pixel(pix, tx_idle_on ? $urandom_range(0, 9) : 0, -1, '0);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_dim(input int top);
        if ($urandom_range(0, 9) == 0) return '0;
        return CFG_DATA_W'($urandom_range(1, top));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_key();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 24'hFFFFFF;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic void refresh_palette();
        palette[0] = '0;
        palette[1] = cfg_key;
        palette[2] = PIX_W'($urandom);
        palette[3] = PIX_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Width 4, height 2 first: the row-1 image walks a
    // run closed by a black pixel, a key-colored run at row end, and a
    // row-0 pixel that closes three records at once. Then a key write
    // while its color is the open run, a geometry write that drops a
    // half-built row, and zero width/height acting as one.
    // ------------------------------------------------------------------
    typedef enum logic {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] value;    // pixel, or register data
        int                    n_known;  // -1: predictor decides
        t_rec                  known;
    } t_step;

    t_step directed_steps [24] = '{
        '{STEP_WRITE, CFG_WIDTH,  24'd4,       -1, '0},
        '{STEP_WRITE, CFG_HEIGHT, 24'd2,       -1, '0},
        '{STEP_WRITE, CFG_KEY,    24'h123456,  -1, '0},
        // row 1
        '{STEP_PIXEL, CFG_WIDTH,  24'hFFFFFF,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'hFFFFFF,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h000000,   1,
          '{10'd1, 10'd0, 10'd1, 24'hFFFFFF, 1'b0, 1'b1}},
        '{STEP_PIXEL, CFG_WIDTH,  24'h123456,   0, '0},  // black and key runs both dropped
        // row 0
        '{STEP_PIXEL, CFG_WIDTH,  24'h800000,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h000001,   1,
          '{10'd0, 10'd0, 10'd0, 24'h800000, 1'b0, 1'b1}},
        '{STEP_PIXEL, CFG_WIDTH,  24'h000001,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'hABCDEF,  -1, '0},  // color change + row end + marker
        // next image, key moved onto the open run
        '{STEP_PIXEL, CFG_WIDTH,  24'h654321,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h654321,   0, '0},
        '{STEP_WRITE, CFG_KEY,    24'h654321,  -1, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h654321,   0, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h000002,   1,
          '{10'd1, 10'd3, 10'd3, 24'h000002, 1'b0, 1'b1}},
        '{STEP_PIXEL, CFG_WIDTH,  24'h777777,   0, '0},
        // width 0 acts as 1 and throws away the open row-0 run
        '{STEP_WRITE, CFG_WIDTH,  24'd0,       -1, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h0000FF,   1,
          '{10'd1, 10'd0, 10'd0, 24'h0000FF, 1'b0, 1'b1}},
        '{STEP_PIXEL, CFG_WIDTH,  24'h654321,   1,
          '{10'd0, 10'd0, 10'd0, 24'h000000, 1'b1, 1'b1}},
        // height 0 acts as 1: every pixel ends the image
        '{STEP_WRITE, CFG_HEIGHT, 24'd0,       -1, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'hFFFFFF,  -1, '0},
        '{STEP_WRITE, CFG_KEY,    24'h000000,  -1, '0},
        '{STEP_PIXEL, CFG_WIDTH,  24'h000000,   1,
          '{10'd0, 10'd0, 10'd0, 24'h000000, 1'b1, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Record receiver: a drawn stall before every record, or the long
    // hold-off when the sequence asks for it
    // ------------------------------------------------------------------
    initial begin : record_sink
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                n = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                n = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // ------------------------------------------------------------------
    // Record checker: each taken record against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rec got;
        t_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_row_index, o_start_column, o_end_column, o_run_color,
                    o_is_end_marker, o_last_of_burst};
            if (expected_records.size() == 0) begin
                $error("record with none owed: row %0d cols %0d..%0d color %06h",
                       got.row_index, got.start_column, got.end_column, got.run_color);
                errors++;
            end else begin
                want = expected_records.pop_front();
                records_checked++;
                if (got.row_index !== want.row_index) begin
                    $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
                    errors++;
                end
                if (got.start_column !== want.start_column) begin
                    $error("start_column: expected %0d, got %0d",
                           want.start_column, got.start_column);
                    errors++;
                end
                if (got.end_column !== want.end_column) begin
                    $error("end_column: expected %0d, got %0d",
                           want.end_column, got.end_column);
                    errors++;
                end
                if (got.run_color !== want.run_color) begin
                    $error("run_color: expected %06h, got %06h", want.run_color, got.run_color);
                    errors++;
                end
                if (got.is_end_marker !== want.is_end_marker) begin
                    $error("is_end_marker: expected %0b, got %0b",
                           want.is_end_marker, got.is_end_marker);
                    errors++;
                end
                if (got.last_of_burst !== want.last_of_burst) begin
                    $error("last_of_burst: expected %0b, got %0b",
                           want.last_of_burst, got.last_of_burst);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no request moving on either side
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_done;
        int phase_no;
        int n_items;
        random_done = 0;
        phase_no    = 0;
        restart_image();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == STEP_WRITE) begin
                write_reg(directed_steps[k].reg_index, directed_steps[k].value);
            end else begin
                send_pixel(directed_steps[k].value[PIX_W-1:0], $urandom_range(0, 9),
                           directed_steps[k].n_known, directed_steps[k].known);
            end
        end

        // Small random images. Phases stop at random points, so the next
        // geometry write often lands mid-row and drops the open run.
        while (random_done < RANDOM_ITEMS) begin
            phase_no++;
            if (phase_no == 1 || $urandom_range(0, 1)) write_reg(CFG_WIDTH, draw_dim(8));
            if (phase_no == 1 || $urandom_range(0, 1)) write_reg(CFG_HEIGHT, draw_dim(4));
            if ($urandom_range(0, 1)) write_reg(CFG_KEY, draw_key());
            refresh_palette();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            n_items    = $urandom_range(25, 45);
            if (phase_no == 2) begin
                // receiver goes quiet while pixels pour in back to back
                tx_idle_on   = 1'b0;
                hold_off_req = 1'b1;
            end
            if (phase_no == 3) begin
                // sender stops mid-image until the DUT owes nothing
                run_pixels(n_items / 2, 60);
                pause_sender();
                run_pixels(n_items - n_items / 2, 60);
            end else begin
                run_pixels(n_items, 60);
            end
            random_done += n_items;
        end

        // Oversized width saturates to 1024 with one row: the start of one long row.
        write_reg(CFG_WIDTH, 24'd2047);
        write_reg(CFG_HEIGHT, 24'd0);
        write_reg(CFG_KEY, draw_key());
        refresh_palette();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        run_pixels(LONG_ITEMS, 80);

        // One column, oversized height saturates to 1024 rows counting down from 1023.
        write_reg(CFG_WIDTH, 24'd0);
        write_reg(CFG_HEIGHT, 24'd2047);
        write_reg(CFG_KEY, 24'hFFFFFF);
        refresh_palette();
        run_pixels(LONG_ITEMS, 60);

        pause_sender();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d pixels, %0d records checked, %0d register writes",
                 pixels_sent, records_checked, writes_done);
        $display("including saturated and zero geometry, key changes and a full record queue");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
